[rtl/zero_selector_coeff_codec_core_macros.svh]
// Assertion macros shared by the codec RTL.
`ifndef ZERO_SELECTOR_COEFF_CODEC_CORE_MACROS_SVH
`define ZERO_SELECTOR_COEFF_CODEC_CORE_MACROS_SVH

// Overlapping implication, checked on every clock edge outside reset.
`define ZSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("zsc check failed");

// Implication whose consequent is checked at the next clock edge.
`define ZSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("zsc check failed");

`endif

[rtl/zsc_pkg.sv]
// Package for the zero-selector coefficient codec: types and constants.
package zsc_pkg;

    localparam int SEL_W       = 32;
    localparam int COEF_W      = 9;
    localparam int BYTE_W      = 8;
    localparam int SEL_BITS_DEF = 32;

    localparam logic [COEF_W-1:0] COEF_TOP = 9'd256;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode             mode;
        logic [COEF_W-1:0] coefficient;
        logic [BYTE_W-1:0] code_byte;
        logic [SEL_W-1:0]  selector;
        logic              last;
    } t_item;

    typedef struct packed {
        logic [COEF_W-1:0] value;
        logic [SEL_W-1:0]  selector;
        logic              overflow;
        logic              last;
    } t_result;

endpackage

[rtl/zsc_step.sv]
// Per-word datapath: result and next codec state from one word and the current state.
module zsc_step
    import zsc_pkg::*;
#(
    parameter int SEL_BITS = SEL_BITS_DEF,
    parameter int CNT_W    = $clog2(SEL_BITS + 1)
) (
    input  t_item             i_item,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [SEL_W-1:0]  i_acc,
    input  logic              i_ovf,
    output t_result           o_result,
    output logic [CNT_W-1:0]  o_count,
    output logic [SEL_W-1:0]  o_acc,
    output logic              o_ovf
);

    logic             room;
    logic [SEL_W-1:0] count_bit;
    logic [SEL_W-1:0] sel_shifted;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] count_upd;
    logic [SEL_W-1:0] acc_upd;
    logic             ovf_upd;

    assign room        = (i_count < CNT_W'(SEL_BITS));
    assign count_bit   = SEL_W'(1) << i_count;
    assign sel_shifted = i_item.selector >> i_count;
    assign count_inc   = CNT_W'(i_count + 1'b1);

    always_comb begin
        count_upd = i_count;
        acc_upd   = i_acc;
        ovf_upd   = i_ovf;
        o_result  = '0;
        o_result.last = i_item.last;
        unique case (i_item.mode)
            MODE_ENCODE: begin
                o_result.value = {1'b0, i_item.coefficient[BYTE_W-1:0]};
                if (i_item.coefficient[BYTE_W-1:0] == '0) begin
                    if (!room) begin
                        ovf_upd = 1'b1;
                    end else begin
                        if (i_item.coefficient == COEF_TOP) begin
                            acc_upd = i_acc | count_bit;
                        end
                        count_upd = count_inc;
                    end
                end
                o_result.selector = acc_upd;
                o_result.overflow = ovf_upd;
            end
            MODE_DECODE: begin
                o_result.value = {1'b0, i_item.code_byte};
                if (i_item.code_byte == '0 && room) begin
                    // A zero byte within capacity is restored from its selector bit.
                    o_result.value = {sel_shifted[0], {BYTE_W{1'b0}}};
                    count_upd      = count_inc;
                end
            end
            default: begin
                o_result.value = '0;
            end
        endcase

        // The end of a polynomial clears all codec state.
        if (i_item.last) begin
            o_count = '0;
            o_acc   = '0;
            o_ovf   = 1'b0;
        end else begin
            o_count = count_upd;
            o_acc   = acc_upd;
            o_ovf   = ovf_upd;
        end
    end

endmodule

[rtl/zero_selector_coeff_codec_core.sv]
// Top level of the zero-selector coefficient codec.
//
// Input channel: i_valid with o_stall; a word is taken at a rising edge with
// i_valid high and o_stall low. Each word carries one coefficient (encode) or
// one code byte plus the polynomial's selector word (decode), and i_last_in
// marks the final word of a polynomial.
// Output channel: o_valid with i_stall; one result word for every input word,
// in order. In encode the selector and overflow outputs hold the running
// values, complete on the word marked by o_last_out.
// The word is registered on entry, then the step logic writes the result
// register. One word is taken every cycle while o_stall is low; the limit is
// the single compare, shift and counter update between the two registers.
// While the receiver stalls, the result register holds its word and the input
// register can still fill, after which o_stall rises.
// Synchronous active-low reset empties both registers and clears the
// candidate counter, selector accumulator and overflow flag.
`include "zero_selector_coeff_codec_core_macros.svh"

module zero_selector_coeff_codec_core
    import zsc_pkg::*;
#(
    parameter int SEL_BITS = SEL_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_mode,
    input  logic [COEF_W-1:0] i_coefficient,
    input  logic [BYTE_W-1:0] i_code_byte,
    input  logic [SEL_W-1:0]  i_selector_in,
    input  logic              i_last_in,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [COEF_W-1:0] o_out_value,
    output logic [SEL_W-1:0]  o_selector_out,
    output logic              o_overflow,
    output logic              o_last_out
);

    localparam int CNT_W = $clog2(SEL_BITS + 1);

    t_item            r_in;
    logic             r_in_valid;
    t_result          r_out;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_count;
    logic [SEL_W-1:0] r_acc;
    logic             r_ovf;

    t_result          n_out;
    logic [CNT_W-1:0] n_count;
    logic [SEL_W-1:0] n_acc;
    logic             n_ovf;
    logic             advance;

    assign advance = r_in_valid && !(r_out_valid && i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;

    zsc_step #(
        .SEL_BITS (SEL_BITS),
        .CNT_W    (CNT_W)
    ) u_step (
        .i_item   (r_in),
        .i_count  (r_count),
        .i_acc    (r_acc),
        .i_ovf    (r_ovf),
        .o_result (n_out),
        .o_count  (n_count),
        .o_acc    (n_acc),
        .o_ovf    (n_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in.mode        <= t_mode'(i_mode);
            r_in.coefficient <= i_coefficient;
            r_in.code_byte   <= i_code_byte;
            r_in.selector    <= i_selector_in;
            r_in.last        <= i_last_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                r_acc       <= n_acc;
                r_ovf       <= n_ovf;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_value    = r_out.value;
    assign o_selector_out = r_out.selector;
    assign o_overflow     = r_out.overflow;
    assign o_last_out     = r_out.last;

    `ZSC_ASSERT_IMP(a_count_in_range, 1'b1, r_count <= CNT_W'(SEL_BITS))
    `ZSC_ASSERT_IMP(a_ovf_at_capacity, r_ovf, r_count == CNT_W'(SEL_BITS))
    `ZSC_ASSERT_IMP(a_acc_below_count, 1'b1, (r_acc >> r_count) == '0)
    `ZSC_ASSERT_NEXT(a_clear_after_last, advance && r_in.last,
        r_count == '0 && r_acc == '0 && !r_ovf)

endmodule

[bench/zero_selector_coeff_codec_core_test.sv]
// Self-checking testbench for the zero-selector coefficient codec core.
module zero_selector_coeff_codec_core_test
    import zsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PERIOD       = 10;
    localparam int CAPACITY     = SEL_BITS_DEF;
    localparam int POLY_LEN     = 256;
    localparam int RANDOM_WORDS = 1500;
    localparam int CYCLE_LIMIT  = 500000;

    // Tracks the codec's running state and queues the result word each input word should give.
    class codec_scoreboard;
        t_result    expected_q[$];
        logic [5:0] cand_count;
        logic [31:0] sel_acc;
        logic       ovf;
        int errors;
        int encode_words;
        int decode_words;
        int overflow_words;
        int top_restores;

        function new();
            clear_poly();
            errors = 0;
            encode_words = 0;
            decode_words = 0;
            overflow_words = 0;
            top_restores = 0;
        endfunction

        function void clear_poly();
            cand_count = '0;
            sel_acc = '0;
            ovf = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_word(t_mode mode, logic [COEF_W-1:0] coef,
                                logic [BYTE_W-1:0] cbyte, logic [SEL_W-1:0] sel,
                                logic last);
            t_result r;
            r.last = last;
            if (mode == MODE_ENCODE) begin
                encode_words++;
                r.value = {1'b0, coef[7:0]};
                if (coef[7:0] == 8'h00) begin
                    // Beyond capacity the selector and count are left alone.
                    if (cand_count >= CAPACITY) begin
                        ovf = 1'b1;
                    end else begin
                        if (coef == COEF_TOP) sel_acc[cand_count[4:0]] = 1'b1;
                        cand_count++;
                    end
                end
                r.selector = sel_acc;
                r.overflow = ovf;
                if (ovf) overflow_words++;
            end else begin
                decode_words++;
                r.value = {1'b0, cbyte};
                if (cbyte == 8'h00 && cand_count < CAPACITY) begin
                    r.value = {sel[cand_count[4:0]], 8'h00};
                    if (r.value == COEF_TOP) top_restores++;
                    cand_count++;
                end
                r.selector = '0;
                r.overflow = 1'b0;
            end
            expected_q.push_back(r);
            if (last) clear_poly();
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $error("unexpected result word: out_value %0d", got.value);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.value !== want.value) begin
                $error("out_value: expected %0d, got %0d", want.value, got.value);
                errors++;
            end
            if (got.selector !== want.selector) begin
                $error("selector_out: expected %h, got %h", want.selector, got.selector);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_out: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_mode = 1'b0;
    logic [COEF_W-1:0] i_coefficient = '0;
    logic [BYTE_W-1:0] i_code_byte = '0;
    logic [SEL_W-1:0]  i_selector_in = '0;
    logic              i_last_in = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [COEF_W-1:0] o_out_value;
    logic [SEL_W-1:0]  o_selector_out;
    logic              o_overflow;
    logic              o_last_out;

    codec_scoreboard   sb = new();
    logic [COEF_W-1:0] poly_q[$];
    bit                quiet = 1'b0;
    int                words_sent = 0;
    int                polys = 0;

    zero_selector_coeff_codec_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_coefficient  (i_coefficient),
        .i_code_byte    (i_code_byte),
        .i_selector_in  (i_selector_in),
        .i_last_in      (i_last_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_value    (o_out_value),
        .o_selector_out (o_selector_out),
        .o_overflow     (o_overflow),
        .o_last_out     (o_last_out)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_word(t_mode'(i_mode), i_coefficient, i_code_byte, i_selector_in,
                             i_last_in);
            end
            if (o_valid && !i_stall) begin
                sb.check_result(t_result'({o_out_value, o_selector_out, o_overflow,
                                           o_last_out}));
            end
        end
    end

    function automatic int draw_idle();
        if (quiet) return 0;
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef(int pct);
        if ($urandom_range(0, 99) < pct) return $urandom_range(0, 1) ? COEF_TOP : 9'd0;
        return 9'($urandom_range(0, 511));
    endfunction

    function automatic void build_poly(int len, int pct);
        poly_q.delete();
        repeat (len) poly_q.push_back(pick_coef(pct));
    endfunction

    // Selector word a correct encoder produces for the polynomial held in poly_q.
    function automatic logic [SEL_W-1:0] poly_selector();
        logic [SEL_W-1:0] s;
        int k;
        s = '0;
        k = 0;
        foreach (poly_q[i]) begin
            if (poly_q[i][7:0] == 8'h00) begin
                if (k < CAPACITY && poly_q[i] == COEF_TOP) s[k] = 1'b1;
                k++;
            end
        end
        return s;
    endfunction

    // Valid stays high after acceptance; the next call either replaces the word or drops valid.
    task automatic send_word(t_mode mode, logic [COEF_W-1:0] coef, logic [BYTE_W-1:0] cbyte,
                             logic [SEL_W-1:0] sel, logic last);
        int gap;
        gap = draw_idle();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_coefficient <= coef;
        i_code_byte   <= cbyte;
        i_selector_in <= sel;
        i_last_in     <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_encode_poly();
        foreach (poly_q[i]) begin
            send_word(MODE_ENCODE, poly_q[i], 8'($urandom()), $urandom(),
                      i == poly_q.size() - 1);
        end
    endtask

    task automatic send_decode_poly(logic [SEL_W-1:0] sel);
        foreach (poly_q[i]) begin
            send_word(MODE_DECODE, 9'($urandom_range(0, 511)), poly_q[i][7:0], sel,
                      i == poly_q.size() - 1);
        end
    endtask

    // Both modes within one polynomial share the candidate count.
    task automatic send_mixed_poly(int len, int pct);
        logic [SEL_W-1:0] sel;
        logic [BYTE_W-1:0] b;
        t_mode m;
        sel = $urandom();
        for (int i = 0; i < len; i++) begin
            m = $urandom_range(0, 1) ? MODE_DECODE : MODE_ENCODE;
            b = ($urandom_range(0, 99) < pct) ? 8'h00 : 8'($urandom_range(1, 255));
            send_word(m, pick_coef(pct), b, ($urandom_range(0, 7) == 0) ? $urandom() : sel,
                      i == len - 1);
        end
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = draw_idle();
            @(negedge i_clk);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("zero_selector_coeff_codec_core_test: done, errors");
        $finish;
    end

    initial begin : stimulus
        int len;
        int pct;
        int kind;
        int goal;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes, both zero-byte coefficients, and coefficients whose low byte is non-zero.
        poly_q = '{9'd0, 9'd256, 9'd255, 9'd1, 9'd128, 9'd511, 9'd257, 9'd256, 9'd0};
        send_encode_poly();
        send_decode_poly(poly_selector());
        poly_q = '{9'd0, 9'd0, 9'd0};
        send_decode_poly(32'hFFFF_FFFF);
        send_word(MODE_ENCODE, COEF_TOP, 8'hFF, 32'h0, 1'b0);
        send_word(MODE_DECODE, 9'h1FF, 8'h00, 32'h0000_0002, 1'b0);
        send_word(MODE_ENCODE, 9'd0, 8'h00, 32'hFFFF_FFFF, 1'b1);
        hold_until_drained();

        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal) begin
            quiet = ($urandom_range(0, 4) == 0);
            len = ($urandom_range(0, 19) == 0) ? POLY_LEN : $urandom_range(1, 48);
            case ($urandom_range(0, 3))
                0: pct = 0;
                1: pct = 15;
                2: pct = 50;
                default: pct = 95;
            endcase
            kind = $urandom_range(0, 9);
            build_poly(len, pct);
            if (kind < 7) begin
                // Round trip; now and then the decode gets a corrupted selector.
                send_encode_poly();
                send_decode_poly((kind == 6) ? $urandom() : poly_selector());
            end else if (kind < 9) begin
                send_mixed_poly(len, pct);
            end else begin
                send_decode_poly($urandom());
            end
            polys++;
            if (polys % 16 == 5) hold_until_drained();
        end

        hold_until_drained();
        repeat (4) @(posedge i_clk);
        $display("Checked %0d encode and %0d decode words over %0d random polynomials.",
                 sb.encode_words, sb.decode_words, polys);
        $display("Overflow was flagged on %0d encode words; %0d zero bytes decoded to 256.",
                 sb.overflow_words, sb.top_restores);
        if (sb.errors == 0) begin
            $display("zero_selector_coeff_codec_core_test: done, clean");
        end else begin
            $display("zero_selector_coeff_codec_core_test: done, errors");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/zsc_pkg.sv
rtl/zsc_step.sv
rtl/zero_selector_coeff_codec_core.sv
bench/zero_selector_coeff_codec_core_test.sv
